FILE: hdl/differential_drive_odometry_assert.svh
// Assertion macros used by the odometry sequencer (ddo_ctrl).
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define DDO_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define DDO_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: hdl/ddo_pkg.sv
// Types, constants and helper functions of the odometry block.
package ddo_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int FRAC_BITS    = 16;

	localparam int DIST_W    = 33;               // |dL +/- dR|
	localparam int TWO_PI_W  = 29;
	localparam int TH_SHIFT  = 26;               // 2*pi is Q3.26
	localparam int MS_W      = 10;
	localparam int SCALED_W  = DIST_W + MS_W;    // distance * 1000
	localparam int DIV_W     = DIST_W + TH_SHIFT + 32;
	localparam int DVSR_W    = 32 + TWO_PI_W;
	localparam int CNT_W     = $clog2(DIV_W + 1);
	localparam int STEP_W    = $clog2(CORDIC_STEPS + 1);
	localparam int TRIG_W    = 34;
	localparam int ACC_W     = 38;
	localparam int POS_W     = 48;
	localparam int PROD_W    = 2 * TRIG_W;
	localparam int ROT_SHIFT = 31;

	localparam logic [TWO_PI_W-1:0] TWO_PI_Q26      = 29'd421657428;
	localparam logic [31:0]         CORDIC_GAIN_Q30 = 32'd652032874;
	localparam logic [31:0]         EIGHTH_TURN     = 32'h2000_0000;
	localparam logic [MS_W-1:0]     MS_PER_S        = 10'd1000;

	localparam logic [31:0] AXLE_RESET   = 32'd13107200;
	localparam logic [15:0] SLIP_RESET   = 16'd0;
	localparam logic [15:0] PERIOD_RESET = 16'd10;

	localparam logic [1:0] REG_AXLE   = 2'd0;
	localparam logic [1:0] REG_SLIP   = 2'd1;
	localparam logic [1:0] REG_PERIOD = 2'd2;

	// Division selects
	localparam logic [1:0] DIV_TH  = 2'd0;
	localparam logic [1:0] DIV_ANG = 2'd1;
	localparam logic [1:0] DIV_LIN = 2'd2;

	// Rotation products: bit 0 picks the slip distance
	localparam logic [1:0] PROD_SUM_COS  = 2'd0;
	localparam logic [1:0] PROD_ORTH_SIN = 2'd1;
	localparam logic [1:0] PROD_SUM_SIN  = 2'd2;
	localparam logic [1:0] PROD_ORTH_COS = 2'd3;

	typedef struct packed {
		logic signed [31:0] delta_left;
		logic signed [31:0] delta_right;
	} ddo_tick_t;

	typedef struct packed {
		logic signed [47:0] pos_x;
		logic signed [47:0] pos_y;
		logic        [31:0] heading;
		logic signed [31:0] linear_velocity;
		logic signed [31:0] angular_velocity;
	} ddo_pose_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_PREP_TH,
		OP_PREP_ANG,
		OP_PREP_ORTH,
		OP_DIV_START,
		OP_DIV_SAVE,
		OP_CORDIC_START,
		OP_MUL_LO,
		OP_MUL_HI,
		OP_ACC,
		OP_COMMIT
	} ddo_op_e;

	typedef struct packed {
		ddo_op_e    op;
		logic [1:0] sel;
	} ddo_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic cordic_busy;
	} ddo_stat_t;

	function automatic logic [31:0] atan_bam(input logic [4:0] k);
		logic [31:0] r;
		unique case (k)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			5'd31: r = 32'h00000000;
		endcase
		return r;
	endfunction

	// Apply a sign to a magnitude and clamp to the 32-bit signed range.
	function automatic logic [31:0] sat_s32(input logic neg, input logic [DIV_W-1:0] mag);
		logic [31:0] r;
		if (neg) begin
			r = (mag >= DIV_W'(64'h8000_0000)) ? 32'h8000_0000 : 32'(0 - mag[31:0]);
		end else begin
			r = (mag >= DIV_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : mag[31:0];
		end
		return r;
	endfunction

endpackage

FILE: hdl/differential_drive_odometry.sv
// Top level of the differential-drive odometry block: register port, sequencer, datapath.
//
//   channel  direction  word         handshake
//   tick     in         ddo_tick_t   tick_valid / tick_ready
//   pose     out        ddo_pose_t   pose_valid / pose_ready
//   config   in         32-bit regs  psel / penable / pwrite, pready tied high
//
// Each tick runs through the shared bit-serial divider, one quotient bit a cycle,
// for the heading change, the turn rate and the forward speed, then 16 CORDIC steps
// and four partial-product rotations (MUL_LO, MUL_HI, ACC); pose_valid rises as the
// commit loads the pose word. Reset clears the pose accumulators and loads the
// register defaults. Commit holds while an older pose word waits for pose_ready;
// a new tick is taken once the word register is loaded.
module differential_drive_odometry
	import ddo_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        tick_valid,
	output logic        tick_ready,
	input  ddo_tick_t   tick,
	output logic        pose_valid,
	input  logic        pose_ready,
	output ddo_pose_t   pose
);

	logic [31:0] track_width_q;
	logic [15:0] slippage_q;
	logic [15:0] tick_period_ms_q;
	logic        reg_wr;
	ddo_cmd_t    cmd;
	ddo_stat_t   stat;

	// Registers sit at byte addresses 4*index; pready is tied high.
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_width_q    <= AXLE_RESET;
			slippage_q       <= SLIP_RESET;
			tick_period_ms_q <= PERIOD_RESET;
		end else if (reg_wr) begin
			// Drop writes to addresses past the last register
			unique case (paddr[3:2])
				REG_AXLE:   track_width_q    <= pwdata;
				REG_SLIP:   slippage_q       <= pwdata[15:0];
				REG_PERIOD: tick_period_ms_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_AXLE:   prdata = track_width_q;
			REG_SLIP:   prdata = {16'd0, slippage_q};
			REG_PERIOD: prdata = {16'd0, tick_period_ms_q};
			default:    prdata = 32'd0;
		endcase
	end

	// Sequencer: steps each tick through load, divide, rotate and commit
	ddo_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_ready (tick_ready),
		.pose_valid (pose_valid),
		.pose_ready (pose_ready),
		.cmd        (cmd),
		.stat       (stat)
	);

	// Datapath: holds the pose accumulators and the output word register
	ddo_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.tick           (tick),
		.track_width    (track_width_q),
		.slippage       (slippage_q),
		.tick_period_ms (tick_period_ms_q),
		.pose           (pose)
	);

endmodule

FILE: hdl/ddo_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module ddo_div
	import ddo_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_W-1:0]  dividend,
	input  logic [DVSR_W-1:0] divisor,
	input  logic [CNT_W-1:0]  steps,
	output logic              busy,
	output logic [DIV_W-1:0]  quotient
);

	logic [DIV_W-1:0]  dq_q;
	logic [DVSR_W-1:0] rem_q;
	logic [DVSR_W-1:0] dvsr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic [DVSR_W:0]   trial;
	logic              fits;

	// Dividend is left-aligned; remainder picks up its top bit each step.
	assign trial = {rem_q, dq_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= steps;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != CNT_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q   <= dividend;
			rem_q  <= '0;
			dvsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DVSR_W'(trial - {1'b0, dvsr_q}) : DVSR_W'(trial);
			dq_q  <= {dq_q[DIV_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = dq_q;

endmodule

FILE: hdl/ddo_cordic.sv
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle.
module ddo_cordic
	import ddo_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [31:0]              angle,
	output logic                     busy,
	output logic signed [TRIG_W-1:0] cos_v,
	output logic signed [TRIG_W-1:0] sin_v
);

	logic signed [TRIG_W-1:0] x_q, y_q, z_q;
	logic [1:0]               quad_q;
	logic [STEP_W-1:0]        step_q;
	logic                     busy_q;
	logic [1:0]               quad;
	logic [31:0]              z_init;
	logic [4:0]               k;
	logic signed [TRIG_W-1:0] x_sh, y_sh, atan_k;

	assign quad   = 2'((angle + EIGHTH_TURN) >> 30);
	assign z_init = angle - {quad, 30'd0};
	assign k      = 5'(step_q);
	assign x_sh   = x_q >>> k;
	assign y_sh   = y_q >>> k;
	assign atan_k = $signed({2'b00, atan_bam(k)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			busy_q <= (step_q != STEP_W'(CORDIC_STEPS - 1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= $signed({2'b00, CORDIC_GAIN_Q30});
			y_q    <= '0;
			z_q    <= TRIG_W'($signed(z_init));
			quad_q <= quad;
		end else if (busy_q) begin
			if (!z_q[TRIG_W-1]) begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - atan_k;
			end else begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + atan_k;
			end
		end
	end

	// Fold the quadrant back in
	always_comb begin
		unique case (quad_q)
			2'd0: begin cos_v = x_q;  sin_v = y_q;  end
			2'd1: begin cos_v = -y_q; sin_v = x_q;  end
			2'd2: begin cos_v = -x_q; sin_v = -y_q; end
			2'd3: begin cos_v = y_q;  sin_v = -x_q; end
		endcase
	end

	assign busy = busy_q;

endmodule

FILE: hdl/ddo_datapath.sv
// Odometry datapath: operand registers, divider, CORDIC, rotation MAC, pose.
module ddo_datapath
	import ddo_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  ddo_cmd_t    cmd,
	output ddo_stat_t   stat,
	input  ddo_tick_t   tick,
	input  logic [31:0] track_width,
	input  logic [15:0] slippage,
	input  logic [15:0] tick_period_ms,
	output ddo_pose_t   pose
);

	logic signed [DIST_W-1:0] sum_q;
	logic [DIST_W-1:0]        asum_q, adiff_q, orth_q;
	logic                     sum_neg_q, diff_neg_q, axle_zero_q;
	logic [DVSR_W-1:0]        d_th_q;
	logic [47:0]              d_ang_q;
	logic [SCALED_W-1:0]      n_ang_q, n_lin_q;
	logic [31:0]              dth_q, half_q, lin_v_q, ang_v_q;
	logic signed [51:0]       pp_lo_q;
	logic signed [50:0]       pp_hi_q;
	logic signed [ACC_W-1:0]  dx_q, dy_q;
	logic signed [POS_W-1:0]  x_q, y_q;
	logic [31:0]              heading_q;
	ddo_pose_t                pose_q;

	logic signed [DIST_W-1:0] sum_v, diff_v;
	logic [15:0]              period;
	logic [DIV_W-1:0]         div_dividend;
	logic [DVSR_W-1:0]        div_divisor;
	logic [CNT_W-1:0]         div_steps;
	logic [DIV_W-1:0]         quotient;
	logic signed [TRIG_W-1:0] cos_v, sin_v, mul_dist, mul_trig;
	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]  term;
	logic [48:0]              orth_full;
	logic signed [POS_W:0]    x_next, y_next;

	assign sum_v     = DIST_W'(tick.delta_left) + DIST_W'(tick.delta_right);
	assign diff_v    = DIST_W'(tick.delta_right) - DIST_W'(tick.delta_left);
	assign period    = (tick_period_ms == 16'd0) ? 16'd1 : tick_period_ms;
	assign orth_full = 49'(asum_q) * 49'(slippage);

	always_comb begin
		unique case (cmd.sel)
			DIV_TH: begin
				div_dividend = {adiff_q, (DIV_W - DIST_W)'(0)};
				div_divisor  = d_th_q;
				div_steps    = CNT_W'(DIV_W);
			end
			DIV_ANG: begin
				div_dividend = {n_ang_q, (DIV_W - SCALED_W)'(0)};
				div_divisor  = DVSR_W'(d_ang_q);
				div_steps    = CNT_W'(SCALED_W + FRAC_BITS);
			end
			default: begin
				div_dividend = {n_lin_q, (DIV_W - SCALED_W)'(0)};
				div_divisor  = DVSR_W'({period, 1'b0});
				div_steps    = CNT_W'(SCALED_W);
			end
		endcase
	end

	ddo_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == OP_DIV_START),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.steps    (div_steps),
		.busy     (stat.div_busy),
		.quotient (quotient)
	);

	ddo_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == OP_CORDIC_START),
		.angle  (heading_q + half_q),
		.busy   (stat.cordic_busy),
		.cos_v  (cos_v),
		.sin_v  (sin_v)
	);

	assign mul_dist = cmd.sel[0] ? $signed({1'b0, orth_q}) : TRIG_W'(sum_q);
	assign mul_trig = (cmd.sel == PROD_SUM_COS || cmd.sel == PROD_ORTH_COS) ? cos_v : sin_v;
	assign prod     = $signed({pp_hi_q, 17'd0}) + PROD_W'(pp_lo_q);
	assign term     = ACC_W'(prod >>> ROT_SHIFT);
	assign x_next   = (POS_W + 1)'(x_q) + (POS_W + 1)'(dx_q);
	assign y_next   = (POS_W + 1)'(y_q) + (POS_W + 1)'(dy_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q       <= '0;
			y_q       <= '0;
			heading_q <= '0;
		end else if (cmd.op == OP_COMMIT) begin
			// Saturate position to the 48-bit signed range
			if (x_next[POS_W] != x_next[POS_W-1]) begin
				x_q <= x_next[POS_W] ? {1'b1, (POS_W-1)'(0)} : {1'b0, {(POS_W-1){1'b1}}};
			end else begin
				x_q <= x_next[POS_W-1:0];
			end
			if (y_next[POS_W] != y_next[POS_W-1]) begin
				y_q <= y_next[POS_W] ? {1'b1, (POS_W-1)'(0)} : {1'b0, {(POS_W-1){1'b1}}};
			end else begin
				y_q <= y_next[POS_W-1:0];
			end
			heading_q <= heading_q + dth_q;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				sum_q      <= sum_v;
				sum_neg_q  <= sum_v[DIST_W-1];
				diff_neg_q <= diff_v[DIST_W-1];
				asum_q     <= sum_v[DIST_W-1] ? DIST_W'(-sum_v) : DIST_W'(sum_v);
				adiff_q    <= diff_v[DIST_W-1] ? DIST_W'(-diff_v) : DIST_W'(diff_v);
			end
			OP_PREP_TH: begin
				d_th_q      <= DVSR_W'(track_width) * DVSR_W'(TWO_PI_Q26);
				axle_zero_q <= (track_width == 32'd0);
				n_ang_q     <= SCALED_W'(adiff_q) * SCALED_W'(MS_PER_S);
				n_lin_q     <= SCALED_W'(asum_q) * SCALED_W'(MS_PER_S);
			end
			OP_PREP_ANG: d_ang_q <= 48'(track_width) * 48'(period);
			OP_PREP_ORTH: orth_q <= orth_full[48:16];
			OP_DIV_SAVE: begin
				unique case (cmd.sel)
					DIV_TH: begin
						if (axle_zero_q) begin
							dth_q  <= '0;
							half_q <= '0;
						end else if (diff_neg_q) begin
							dth_q  <= 32'(0 - quotient[31:0]);
							half_q <= 32'(0 - quotient[32:1]);
						end else begin
							dth_q  <= quotient[31:0];
							half_q <= quotient[32:1];
						end
					end
					DIV_ANG: ang_v_q <= axle_zero_q ? 32'd0 : sat_s32(diff_neg_q, quotient);
					default: lin_v_q <= sat_s32(sum_neg_q, quotient);
				endcase
			end
			OP_MUL_LO: pp_lo_q <= mul_dist * $signed({1'b0, mul_trig[16:0]});
			OP_MUL_HI: pp_hi_q <= mul_dist * $signed(mul_trig[TRIG_W-1:17]);
			OP_ACC: begin
				unique case (cmd.sel)
					PROD_SUM_COS:  dx_q <= term;
					PROD_ORTH_SIN: dx_q <= dx_q - term;
					PROD_SUM_SIN:  dy_q <= term;
					PROD_ORTH_COS: dy_q <= dy_q + term;
				endcase
			end
			OP_COMMIT: begin
				pose_q.pos_x            <= (x_next[POS_W] != x_next[POS_W-1])
					? (x_next[POS_W] ? {1'b1, (POS_W-1)'(0)} : {1'b0, {(POS_W-1){1'b1}}})
					: x_next[POS_W-1:0];
				pose_q.pos_y            <= (y_next[POS_W] != y_next[POS_W-1])
					? (y_next[POS_W] ? {1'b1, (POS_W-1)'(0)} : {1'b0, {(POS_W-1){1'b1}}})
					: y_next[POS_W-1:0];
				pose_q.heading          <= heading_q + dth_q;
				pose_q.linear_velocity  <= lin_v_q;
				pose_q.angular_velocity <= ang_v_q;
			end
			default: ;
		endcase
	end

	assign pose = pose_q;

endmodule

FILE: hdl/ddo_ctrl.sv
// Odometry sequencer: walks one tick through the datapath and owns the handshakes.
`include "differential_drive_odometry_assert.svh"

module ddo_ctrl
	import ddo_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      tick_valid,
	output logic      tick_ready,
	output logic      pose_valid,
	input  logic      pose_ready,
	output ddo_cmd_t  cmd,
	input  ddo_stat_t stat
);

	typedef enum logic [4:0] {
		S_IDLE,
		S_PREP_TH,
		S_PREP_ANG,
		S_PREP_ORTH,
		S_TH_GO,
		S_TH_RUN,
		S_ANG_GO,
		S_ANG_RUN,
		S_LIN_GO,
		S_LIN_RUN,
		S_ROT_GO,
		S_ROT_RUN,
		S_MUL_LO,
		S_MUL_HI,
		S_ACC,
		S_COMMIT
	} state_t;

	state_t     state_q;
	logic [1:0] prod_q;
	logic       pose_valid_q;
	logic       slot_free;

	assign slot_free  = !pose_valid_q || pose_ready;
	assign tick_ready = (state_q == S_IDLE);
	assign pose_valid = pose_valid_q;

	always_comb begin
		cmd.op  = OP_NONE;
		cmd.sel = DIV_TH;
		unique case (state_q)
			S_IDLE:      if (tick_valid) cmd.op = OP_LOAD;
			S_PREP_TH:   cmd.op = OP_PREP_TH;
			S_PREP_ANG:  cmd.op = OP_PREP_ANG;
			S_PREP_ORTH: cmd.op = OP_PREP_ORTH;
			S_TH_GO:     cmd.op = OP_DIV_START;
			S_TH_RUN:    if (!stat.div_busy) cmd.op = OP_DIV_SAVE;
			S_ANG_GO: begin
				cmd.op  = OP_DIV_START;
				cmd.sel = DIV_ANG;
			end
			S_ANG_RUN: begin
				cmd.sel = DIV_ANG;
				if (!stat.div_busy) cmd.op = OP_DIV_SAVE;
			end
			S_LIN_GO: begin
				cmd.op  = OP_DIV_START;
				cmd.sel = DIV_LIN;
			end
			S_LIN_RUN: begin
				cmd.sel = DIV_LIN;
				if (!stat.div_busy) cmd.op = OP_DIV_SAVE;
			end
			S_ROT_GO:    cmd.op = OP_CORDIC_START;
			S_ROT_RUN:   cmd.op = OP_NONE;
			S_MUL_LO: begin
				cmd.op  = OP_MUL_LO;
				cmd.sel = prod_q;
			end
			S_MUL_HI: begin
				cmd.op  = OP_MUL_HI;
				cmd.sel = prod_q;
			end
			S_ACC: begin
				cmd.op  = OP_ACC;
				cmd.sel = prod_q;
			end
			S_COMMIT:    if (slot_free) cmd.op = OP_COMMIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			prod_q       <= '0;
			pose_valid_q <= 1'b0;
		end else begin
			// Raise on commit, hold until the word is taken
			pose_valid_q <= (state_q == S_COMMIT && slot_free) || (pose_valid_q && !pose_ready);
			unique case (state_q)
				S_IDLE:      if (tick_valid) state_q <= S_PREP_TH;
				S_PREP_TH:   state_q <= S_PREP_ANG;
				S_PREP_ANG:  state_q <= S_PREP_ORTH;
				S_PREP_ORTH: state_q <= S_TH_GO;
				S_TH_GO:     state_q <= S_TH_RUN;
				S_TH_RUN:    if (!stat.div_busy) state_q <= S_ANG_GO;
				S_ANG_GO:    state_q <= S_ANG_RUN;
				S_ANG_RUN:   if (!stat.div_busy) state_q <= S_LIN_GO;
				S_LIN_GO:    state_q <= S_LIN_RUN;
				S_LIN_RUN:   if (!stat.div_busy) state_q <= S_ROT_GO;
				S_ROT_GO:    state_q <= S_ROT_RUN;
				S_ROT_RUN: begin
					if (!stat.cordic_busy) begin
						state_q <= S_MUL_LO;
						prod_q  <= PROD_SUM_COS;
					end
				end
				S_MUL_LO:    state_q <= S_MUL_HI;
				S_MUL_HI:    state_q <= S_ACC;
				S_ACC: begin
					prod_q  <= prod_q + 1'b1;
					state_q <= (prod_q == PROD_ORTH_COS) ? S_COMMIT : S_MUL_LO;
				end
				S_COMMIT: begin
					if (slot_free) state_q <= S_IDLE;
				end
			endcase
		end
	end

	`DDO_ASSERT_NOW(a_commit_slot, cmd.op == OP_COMMIT, slot_free, "commit over an untaken pose word")
	`DDO_ASSERT_NEXT(a_load_busy, cmd.op == OP_LOAD, !tick_ready, "tick taken while a tick is in work")
	`DDO_ASSERT_NOW(a_div_start_idle, cmd.op == OP_DIV_START, !stat.div_busy, "divider restarted while busy")
	`DDO_ASSERT_NOW(a_rot_start_idle, cmd.op == OP_CORDIC_START, !stat.cordic_busy, "CORDIC restarted while busy")

endmodule
